FILE: sv/bfi_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and helpers for the brainfuck interpreter core
// no dependencies; imported by the top, bfi_ctrl, bfi_datapath and the testbench

package bfi_pkg;

  localparam int BFI_PROGRAM_DEPTH = 4096;
  localparam int BFI_CELL_DEPTH    = 1024;
  localparam int BFI_NEST_DEPTH    = 256;

  localparam int PC_OUT_W   = 13;
  localparam int ACTIVE_W   = 11;
  localparam int ACTIVE_MAX = 2047;

  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_PUT   = 8'h2E;
  localparam logic [7:0] CH_GET   = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_NOP   = 8'h23;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_EXECUTED  = 3'd1,
    ST_HALTED    = 3'd2,
    ST_UNMATCHED = 3'd3,
    ST_UNCLOSED  = 3'd4,
    ST_CAPACITY  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    SYM_NONE  = 4'd0,
    SYM_RIGHT = 4'd1,
    SYM_LEFT  = 4'd2,
    SYM_INC   = 4'd3,
    SYM_DEC   = 4'd4,
    SYM_PUT   = 4'd5,
    SYM_GET   = 4'd6,
    SYM_OPEN  = 4'd7,
    SYM_CLOSE = 4'd8,
    SYM_NOP   = 4'd9
  } sym_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_SET_ERR,
    OP_STORE,
    OP_PAIR_A,
    OP_PAIR_B,
    OP_START,
    OP_SWEEP,
    OP_EXEC
  } dp_op_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_PAIR_A,
    S_PAIR_B,
    S_SWEEP,
    S_EXEC,
    S_RESP
  } state_t;

  typedef struct packed {
    logic    latch;
    dp_op_t  op;
    logic    set_status;
    status_t status;
    logic    load_out;
  } bfi_cmd_t;

  typedef struct packed {
    cmd_t    command;
    sym_t    sym;
    logic    err_set;
    status_t err_code;
    logic    depth_zero;
    logic    depth_full;
    logic    len_full;
    logic    halted;
    logic    sweep_last;
    logic    out_free;
  } bfi_stat_t;

  function automatic sym_t symbol_of(input logic [7:0] c);
    sym_t s;
    case (c)
      CH_RIGHT: s = SYM_RIGHT;
      CH_LEFT:  s = SYM_LEFT;
      CH_INC:   s = SYM_INC;
      CH_DEC:   s = SYM_DEC;
      CH_PUT:   s = SYM_PUT;
      CH_GET:   s = SYM_GET;
      CH_OPEN:  s = SYM_OPEN;
      CH_CLOSE: s = SYM_CLOSE;
      CH_NOP:   s = SYM_NOP;
      default:  s = SYM_NONE;
    endcase
    return s;
  endfunction

endpackage

FILE: sv/bfi_in_if.sv
`timescale 1ns / 1ps
// request channel of the interpreter core: command and data byte
// no dependencies

interface bfi_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink (input valid, command, data_byte, output ready);
endinterface

FILE: sv/bfi_out_if.sv
`timescale 1ns / 1ps
// result channel of the interpreter core: status, output byte, program counter
// no dependencies

interface bfi_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  out_byte;
  logic        out_valid;
  logic        input_used;
  logic [12:0] program_counter;

  modport source (output valid, status, out_byte, out_valid, input_used,
                  program_counter, input ready);
  modport sink (input valid, status, out_byte, out_valid, input_used,
                program_counter, output ready);
endinterface

FILE: sv/brainfuck_interpreter_core_top.sv
`timescale 1ns / 1ps
// top level of the brainfuck interpreter core: request/result channels, apb register
// depends on bfi_pkg, bfi_in_if, bfi_out_if, bfi_ctrl, bfi_datapath
//
//   channel  | kind          | payload
//   ---------+---------------+------------------------------------------------
//   item     | valid/ready   | command, data_byte
//   result   | valid/ready   | status, out_byte, out_valid, input_used,
//            |               | program_counter
//   apb      | psel/penable  | active_cells at byte address 0
//
// a step: decode with memory reads, execute, then the result register
// a clear, plain load or any refused request: decode, then the result register
// a ']' load: decode with stack read, two partner table writes, then the result
// start: decode, a sweep that clears one cell per cycle, then the result register
// after reset all cells are swept to zero before item.ready rises
// a new request is taken while the previous result waits on result.ready

module brainfuck_interpreter_core_top import bfi_pkg::*; #(
  parameter int PROGRAM_DEPTH = BFI_PROGRAM_DEPTH,
  parameter int CELL_DEPTH    = BFI_CELL_DEPTH,
  parameter int NEST_DEPTH    = BFI_NEST_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  bfi_in_if.sink       item,
  bfi_out_if.source    result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET =
    (CELL_DEPTH > ACTIVE_MAX) ? ACTIVE_W'(ACTIVE_MAX) : ACTIVE_W'(CELL_DEPTH);

  logic [ACTIVE_W-1:0] active_cells;
  bfi_cmd_t            ctl;
  bfi_stat_t           stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(active_cells) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cells <= ACTIVE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      active_cells <= pwdata[ACTIVE_W-1:0];
    end
  end

  bfi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  bfi_datapath #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .CELL_DEPTH    (CELL_DEPTH),
    .NEST_DEPTH    (NEST_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .stat            (stat),
    .command         (item.command),
    .data_byte       (item.data_byte),
    .active_cells    (active_cells),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .status          (result.status),
    .out_byte        (result.out_byte),
    .out_valid       (result.out_valid),
    .input_used      (result.input_used),
    .program_counter (result.program_counter)
  );

endmodule

FILE: sv/bfi_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with one registered read port
// no dependencies

module bfi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/bfi_ctrl.sv
`timescale 1ns / 1ps
// controller state machine of the interpreter core
// depends on bfi_pkg; drives bfi_datapath through bfi_cmd_t

module bfi_ctrl import bfi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  bfi_stat_t stat,
  output bfi_cmd_t  ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    ctl.latch      = 1'b0;
    ctl.op         = OP_NONE;
    ctl.set_status = 1'b0;
    ctl.status     = ST_ACCEPTED;
    ctl.load_out   = 1'b0;
    case (state)
      S_INIT: begin
        ctl.op = OP_SWEEP;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl.set_status = 1'b1;
        state_next     = S_RESP;
        if (stat.command == CMD_CLEAR) begin
          ctl.op = OP_CLEAR;
        end else if (stat.err_set) begin
          ctl.status = stat.err_code;
        end else begin
          case (stat.command)
            CMD_LOAD: begin
              if (stat.sym == SYM_NONE) begin
                ctl.op = OP_NONE;
              end else if (stat.sym == SYM_CLOSE && stat.depth_zero) begin
                ctl.op     = OP_SET_ERR;
                ctl.status = ST_UNMATCHED;
              end else if (stat.len_full ||
                           (stat.sym == SYM_OPEN && stat.depth_full)) begin
                ctl.op     = OP_SET_ERR;
                ctl.status = ST_CAPACITY;
              end else begin
                ctl.op = OP_STORE;
                if (stat.sym == SYM_CLOSE) begin
                  state_next = S_PAIR_A;
                end
              end
            end
            CMD_START: begin
              if (!stat.depth_zero) begin
                ctl.op     = OP_SET_ERR;
                ctl.status = ST_UNCLOSED;
              end else begin
                ctl.op     = OP_START;
                state_next = S_SWEEP;
              end
            end
            CMD_STEP: begin
              if (!stat.depth_zero) begin
                ctl.status = ST_UNCLOSED;
              end else if (stat.halted) begin
                ctl.status = ST_HALTED;
              end else begin
                state_next = S_EXEC;
              end
            end
            default: begin
              ctl.op = OP_NONE;
            end
          endcase
        end
      end
      S_PAIR_A: begin
        ctl.op     = OP_PAIR_A;
        state_next = S_PAIR_B;
      end
      S_PAIR_B: begin
        ctl.op     = OP_PAIR_B;
        state_next = S_RESP;
      end
      S_SWEEP: begin
        ctl.op = OP_SWEEP;
        if (stat.sweep_last) begin
          state_next = S_RESP;
        end
      end
      S_EXEC: begin
        ctl.op         = OP_EXEC;
        ctl.set_status = 1'b1;
        ctl.status     = ST_EXECUTED;
        state_next     = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          ctl.load_out = 1'b1;
          in_ready     = 1'b1;
          if (in_valid) begin
            ctl.latch  = 1'b1;
            state_next = S_DECODE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/bfi_datapath.sv
`timescale 1ns / 1ps
// datapath of the interpreter core: program, partner, stack and cell memories,
// pointers, error state and the result register; depends on bfi_pkg, bfi_ram

module bfi_datapath import bfi_pkg::*; #(
  parameter int PROGRAM_DEPTH = BFI_PROGRAM_DEPTH,
  parameter int CELL_DEPTH    = BFI_CELL_DEPTH,
  parameter int NEST_DEPTH    = BFI_NEST_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  bfi_cmd_t            ctl,
  output bfi_stat_t           stat,
  input  logic [1:0]          command,
  input  logic [7:0]          data_byte,
  input  logic [ACTIVE_W-1:0] active_cells,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [2:0]          status,
  output logic [7:0]          out_byte,
  output logic                out_valid,
  output logic                input_used,
  output logic [PC_OUT_W-1:0] program_counter
);

  localparam int PAW = $clog2(PROGRAM_DEPTH);
  localparam int PCW = $clog2(PROGRAM_DEPTH + 1);
  localparam int CAW = $clog2(CELL_DEPTH);
  localparam int SAW = $clog2(NEST_DEPTH);
  localparam int SDW = $clog2(NEST_DEPTH + 1);
  localparam int NW  = (CAW + 1 > ACTIVE_W) ? CAW + 1 : ACTIVE_W;

  cmd_t           command_q;
  logic [7:0]     data_q;
  logic [PCW-1:0] length;
  logic [SDW-1:0] depth;
  logic [PCW-1:0] pc;
  logic [CAW-1:0] cp;
  status_t        err;
  logic [CAW-1:0] sweep;

  status_t    res_status;
  logic [7:0] res_obyte;
  logic       res_ovalid;
  logic       res_used;

  logic           prog_we;
  logic [PAW-1:0] prog_waddr;
  logic [3:0]     prog_wdata;
  logic [3:0]     prog_rdata;
  logic           part_we;
  logic [PAW-1:0] part_waddr;
  logic [PAW-1:0] part_wdata;
  logic [PAW-1:0] part_rdata;
  logic           stk_we;
  logic [SAW-1:0] stk_waddr;
  logic [SAW-1:0] stk_raddr;
  logic [PAW-1:0] stk_rdata;
  logic           cell_we;
  logic [CAW-1:0] cell_waddr;
  logic [7:0]     cell_wdata;
  logic [7:0]     cell_rdata;

  sym_t           sym;
  sym_t           cur;
  logic [SDW-1:0] depth_m1;
  logic [NW-1:0]  ac_ext;
  logic [NW-1:0]  cnt;
  logic [NW-1:0]  cp_ext;
  logic [NW-1:0]  cp_new;
  logic           jump;
  logic           exec_we;
  logic [7:0]     exec_val;
  logic [PCW-1:0] pc_exec;
  logic           sweep_last;

  assign sym        = symbol_of(data_q);
  assign depth_m1   = depth - SDW'(1);
  assign sweep_last = (sweep == CAW'(CELL_DEPTH - 1));

  // status toward the controller
  always_comb begin
    stat.command    = command_q;
    stat.sym        = sym;
    stat.err_set    = (err != ST_ACCEPTED);
    stat.err_code   = err;
    stat.depth_zero = (depth == '0);
    stat.depth_full = (depth == SDW'(NEST_DEPTH));
    stat.len_full   = (length == PCW'(PROGRAM_DEPTH));
    stat.halted     = (pc >= length);
    stat.sweep_last = sweep_last;
    stat.out_free   = !res_valid || res_ready;
  end

  // instruction execution
  always_comb begin
    cur      = sym_t'(prog_rdata);
    ac_ext   = NW'(active_cells);
    cp_ext   = NW'(cp);
    if (ac_ext == '0) begin
      cnt = NW'(1);
    end else if (ac_ext > NW'(CELL_DEPTH)) begin
      cnt = NW'(CELL_DEPTH);
    end else begin
      cnt = ac_ext;
    end
    cp_new   = cp_ext;
    jump     = 1'b0;
    exec_we  = 1'b0;
    exec_val = cell_rdata;
    case (cur)
      SYM_RIGHT: begin
        cp_new = (cp_ext + NW'(1) >= cnt) ? '0 : cp_ext + NW'(1);
      end
      SYM_LEFT: begin
        cp_new = (cp_ext == '0 || cp_ext - NW'(1) >= cnt) ? cnt - NW'(1)
                                                           : cp_ext - NW'(1);
      end
      SYM_INC: begin
        exec_we  = 1'b1;
        exec_val = cell_rdata + 8'd1;
      end
      SYM_DEC: begin
        exec_we  = 1'b1;
        exec_val = cell_rdata - 8'd1;
      end
      SYM_GET: begin
        exec_we  = 1'b1;
        exec_val = data_q;
      end
      SYM_OPEN: begin
        jump = (cell_rdata == 8'd0);
      end
      SYM_CLOSE: begin
        jump = (cell_rdata != 8'd0);
      end
      default: begin
        jump = 1'b0;
      end
    endcase
    pc_exec = (jump ? PCW'(part_rdata) : pc) + PCW'(1);
  end

  // memory ports
  always_comb begin
    prog_we    = (ctl.op == OP_STORE);
    prog_waddr = length[PAW-1:0];
    prog_wdata = sym;

    stk_we    = (ctl.op == OP_STORE) && (sym == SYM_OPEN);
    stk_waddr = depth[SAW-1:0];
    stk_raddr = depth_m1[SAW-1:0];

    part_we = (ctl.op == OP_PAIR_A) || (ctl.op == OP_PAIR_B);
    if (ctl.op == OP_PAIR_B) begin
      part_waddr = stk_rdata;
      part_wdata = length[PAW-1:0];
    end else begin
      part_waddr = length[PAW-1:0];
      part_wdata = stk_rdata;
    end

    if (ctl.op == OP_SWEEP) begin
      cell_we    = 1'b1;
      cell_waddr = sweep;
      cell_wdata = 8'd0;
    end else begin
      cell_we    = (ctl.op == OP_EXEC) && exec_we;
      cell_waddr = cp;
      cell_wdata = exec_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length    <= '0;
      depth     <= '0;
      pc        <= '0;
      cp        <= '0;
      err       <= ST_ACCEPTED;
      sweep     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (ctl.latch) begin
        command_q <= cmd_t'(command);
        data_q    <= data_byte;
      end
      case (ctl.op)
        OP_CLEAR: begin
          length <= '0;
          depth  <= '0;
          pc     <= '0;
          err    <= ST_ACCEPTED;
        end
        OP_SET_ERR: begin
          err <= ctl.status;
        end
        OP_STORE: begin
          if (sym == SYM_OPEN) begin
            depth <= depth + SDW'(1);
          end
          if (sym != SYM_CLOSE) begin
            length <= length + PCW'(1);
          end
        end
        OP_PAIR_B: begin
          depth  <= depth_m1;
          length <= length + PCW'(1);
        end
        OP_START: begin
          cp <= '0;
          pc <= '0;
        end
        OP_SWEEP: begin
          sweep <= sweep_last ? '0 : sweep + CAW'(1);
        end
        OP_EXEC: begin
          cp <= cp_new[CAW-1:0];
          pc <= pc_exec;
        end
        default: begin
          sweep <= sweep;
        end
      endcase
      if (ctl.set_status) begin
        res_status <= ctl.status;
        res_obyte  <= (ctl.op == OP_EXEC && cur == SYM_PUT) ? cell_rdata : 8'd0;
        res_ovalid <= (ctl.op == OP_EXEC) && (cur == SYM_PUT);
        res_used   <= (ctl.op == OP_EXEC) && (cur == SYM_GET);
      end
      if (ctl.load_out) begin
        res_valid       <= 1'b1;
        status          <= res_status;
        out_byte        <= res_obyte;
        out_valid       <= res_ovalid;
        input_used      <= res_used;
        program_counter <= PC_OUT_W'(pc);
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  bfi_ram #(.WIDTH(4), .DEPTH(PROGRAM_DEPTH)) u_prog (
    .clk   (clk),
    .we    (prog_we),
    .waddr (prog_waddr),
    .wdata (prog_wdata),
    .raddr (pc[PAW-1:0]),
    .rdata (prog_rdata)
  );

  bfi_ram #(.WIDTH(PAW), .DEPTH(PROGRAM_DEPTH)) u_part (
    .clk   (clk),
    .we    (part_we),
    .waddr (part_waddr),
    .wdata (part_wdata),
    .raddr (pc[PAW-1:0]),
    .rdata (part_rdata)
  );

  bfi_ram #(.WIDTH(PAW), .DEPTH(NEST_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (length[PAW-1:0]),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  bfi_ram #(.WIDTH(8), .DEPTH(CELL_DEPTH)) u_cells (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cp),
    .rdata (cell_rdata)
  );

endmodule

FILE: test/brainfuck_interpreter_core_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for brainfuck_interpreter_core_top: directed and random programs
// depends on bfi_pkg, bfi_in_if, bfi_out_if and the core rtl; a scoreboard class predicts
// every result while plain tasks drive the request channel and the apb register port

module brainfuck_interpreter_core_top_tb;
  import bfi_pkg::*;

  localparam int PROG_DEPTH = BFI_PROGRAM_DEPTH;
  localparam int CELL_DEPTH = BFI_CELL_DEPTH;
  localparam int NEST_DEPTH = BFI_NEST_DEPTH;
  localparam logic [2:0] ADDR_ACTIVE_CELLS = 3'd0;
  localparam int RANDOM_REQUESTS = 780;
  localparam int LONG_PROG = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    status_t     status;
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        input_used;
    logic [12:0] pc;
  } outcome_t;

  class bf_scoreboard;
    sym_t        prog_mem[PROG_DEPTH];
    int unsigned partner[PROG_DEPTH];
    int unsigned loop_stack[NEST_DEPTH];
    logic [7:0]  cells[CELL_DEPTH];
    int unsigned depth, prog_len, code_ptr, cell_ptr;
    status_t     fault;
    logic [10:0] active_cells;
    outcome_t    awaited[$];
    int          errors, n_requests, n_results;
    int          status_hits[8];

    function new();
      foreach (prog_mem[i]) prog_mem[i] = SYM_NONE;
      foreach (partner[i]) partner[i] = 0;
      foreach (loop_stack[i]) loop_stack[i] = 0;
      foreach (cells[i]) cells[i] = '0;
      foreach (status_hits[i]) status_hits[i] = 0;
      depth = 0;
      prog_len = 0;
      code_ptr = 0;
      cell_ptr = 0;
      fault = ST_ACCEPTED;
      active_cells = 11'(CELL_DEPTH);
      errors = 0;
      n_requests = 0;
      n_results = 0;
    endfunction

    function void set_active(logic [10:0] v);
      active_cells = v;
    endfunction

    function sym_t decode_char(logic [7:0] ch);
      case (ch)
        CH_RIGHT: return SYM_RIGHT;
        CH_LEFT:  return SYM_LEFT;
        CH_INC:   return SYM_INC;
        CH_DEC:   return SYM_DEC;
        CH_PUT:   return SYM_PUT;
        CH_GET:   return SYM_GET;
        CH_OPEN:  return SYM_OPEN;
        CH_CLOSE: return SYM_CLOSE;
        CH_NOP:   return SYM_NOP;
        default:  return SYM_NONE;
      endcase
    endfunction

    function status_t load_char(logic [7:0] ch);
      sym_t        s;
      int unsigned opener;
      s = decode_char(ch);
      if (s == SYM_NONE) return ST_ACCEPTED;
      if (s == SYM_CLOSE && depth == 0) begin
        fault = ST_UNMATCHED;
        return fault;
      end
      if (prog_len >= PROG_DEPTH || (s == SYM_OPEN && depth >= NEST_DEPTH)) begin
        fault = ST_CAPACITY;
        return fault;
      end
      prog_mem[prog_len] = s;
      if (s == SYM_OPEN) begin
        loop_stack[depth] = prog_len;
        depth++;
      end else if (s == SYM_CLOSE) begin
        depth--;
        opener = loop_stack[depth];
        partner[prog_len] = opener;
        partner[opener] = prog_len;
      end
      prog_len++;
      return ST_ACCEPTED;
    endfunction

    function void note_request(cmd_t cmd, logic [7:0] data);
      outcome_t    o;
      int unsigned n, cp, pc;
      o.status = ST_ACCEPTED;
      o.out_byte = '0;
      o.out_valid = 1'b0;
      o.input_used = 1'b0;
      n_requests++;
      if (cmd == CMD_CLEAR) begin
        prog_len = 0;
        depth = 0;
        code_ptr = 0;
        fault = ST_ACCEPTED;
      end else if (fault != ST_ACCEPTED) begin
        o.status = fault;
      end else if (cmd == CMD_LOAD) begin
        o.status = load_char(data);
      end else if (cmd == CMD_START) begin
        if (depth != 0) begin
          fault = ST_UNCLOSED;
          o.status = fault;
        end else begin
          foreach (cells[i]) cells[i] = '0;
          cell_ptr = 0;
          code_ptr = 0;
        end
      end else if (depth != 0) begin
        o.status = ST_UNCLOSED;
      end else if (code_ptr >= prog_len) begin
        o.status = ST_HALTED;
      end else begin
        n = active_cells;
        if (n == 0) n = 1;
        if (n > CELL_DEPTH) n = CELL_DEPTH;
        cp = cell_ptr;
        pc = code_ptr;
        case (prog_mem[pc])
          SYM_RIGHT: cp = (cp + 1 >= n) ? 0 : cp + 1;
          SYM_LEFT:  cp = (cp == 0 || cp - 1 >= n) ? n - 1 : cp - 1;
          SYM_INC:   cells[cp] = cells[cp] + 8'd1;
          SYM_DEC:   cells[cp] = cells[cp] - 8'd1;
          SYM_PUT: begin
            o.out_byte = cells[cp];
            o.out_valid = 1'b1;
          end
          SYM_GET: begin
            cells[cp] = data;
            o.input_used = 1'b1;
          end
          SYM_OPEN:  if (cells[cp] == 0) pc = partner[pc];
          SYM_CLOSE: if (cells[cp] != 0) pc = partner[pc];
          default: ;
        endcase
        cell_ptr = cp;
        code_ptr = pc + 1;
        o.status = ST_EXECUTED;
      end
      o.pc = code_ptr[12:0];
      awaited = {awaited, o};
    endfunction

    function void check_result(logic [2:0] st, logic [7:0] ob, logic ov, logic iu,
                               logic [12:0] pc);
      outcome_t o;
      n_results++;
      if (!$isunknown(st)) status_hits[st]++;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d pc %0d",
                 $time, st, pc);
        return;
      end
      o = awaited.pop_front();
      if (st !== o.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, o.status, st);
      end
      if (ob !== o.out_byte) begin
        errors++;
        $display("%0t: out_byte mismatch, expected %0d, actual %0d", $time, o.out_byte, ob);
      end
      if (ov !== o.out_valid) begin
        errors++;
        $display("%0t: out_valid mismatch, expected %0d, actual %0d", $time, o.out_valid, ov);
      end
      if (iu !== o.input_used) begin
        errors++;
        $display("%0t: input_used mismatch, expected %0d, actual %0d",
                 $time, o.input_used, iu);
      end
      if (pc !== o.pc) begin
        errors++;
        $display("%0t: program_counter mismatch, expected %0d, actual %0d", $time, o.pc, pc);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bfi_in_if  item_ch();
  bfi_out_if res_ch();

  bf_scoreboard sb;
  bit           idle_on;
  bit           hold_req;
  int           n_writes;
  int           n_holds = 0;
  int           quiet_cycles = 0;

  brainfuck_interpreter_core_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] plain_command();
    case ($urandom_range(6))
      0:       return CH_RIGHT;
      1:       return CH_LEFT;
      2:       return CH_INC;
      3:       return CH_DEC;
      4:       return CH_PUT;
      5:       return CH_GET;
      default: return CH_NOP;
    endcase
  endfunction

  function automatic logic [7:0] stray_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CH_OPEN || c == CH_CLOSE);
    return c;
  endfunction

  function automatic logic [10:0] pick_cell_count();
    case ($urandom_range(9))
      0:       return 11'd0;
      1:       return 11'd1;
      2:       return 11'd2;
      3:       return 11'd1023;
      4:       return 11'd1024;
      5:       return 11'd1025;
      6:       return 11'd2047;
      default: return 11'($urandom_range(16, 1));
    endcase
  endfunction

  task automatic send_request(cmd_t cmd, logic [7:0] data);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 35) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.command <= cmd;
    item_ch.data_byte <= data;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    sb.note_request(cmd, data);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic load_text(string s);
    for (int i = 0; i < s.len(); i++) send_request(CMD_LOAD, s[i]);
  endtask

  // balanced random program, brackets nested at most six deep
  task automatic load_program(int unsigned len);
    int unsigned open_cnt;
    int unsigned r;
    logic [7:0]  ch;
    open_cnt = 0;
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (open_cnt > 0 && (len - i <= open_cnt || r < 20)) begin
        ch = CH_CLOSE;
        open_cnt--;
      end else if (len - i > open_cnt + 2 && open_cnt < 6 && r < 35) begin
        ch = CH_OPEN;
        open_cnt++;
      end else if (r < 55) begin
        ch = CH_INC;
      end else if (r < 62) begin
        ch = stray_char();
      end else begin
        ch = plain_command();
      end
      send_request(CMD_LOAD, ch);
    end
  endtask

  task automatic apb_access(bit wr, logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_ACTIVE_CELLS;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_active_cells(logic [10:0] want);
    logic [31:0] rd;
    apb_access(1'b0, 32'd0, rd);
    if (rd !== {21'd0, want}) begin
      sb.errors++;
      $display("%0t: active_cells readback mismatch, expected %0d, actual %0d",
               $time, want, rd);
    end
  endtask

  task automatic write_active_cells(logic [10:0] v);
    logic [31:0] rd;
    apb_access(1'b1, {21'd0, v}, rd);
    sb.set_active(v);
    n_writes++;
    check_active_cells(v);
  endtask

  // result side
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        n_holds++;
      end else begin
        res_ch.ready <= !idle_on || ($urandom_range(99) >= 35);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
      sb.check_result(res_ch.status, res_ch.out_byte, res_ch.out_valid,
                      res_ch.input_used, res_ch.program_counter);
  end

  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no handshake for %0d cycles", $time, quiet_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned target, len, steps, episode, r;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.command = CMD_LOAD;
    item_ch.data_byte = 8'd0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_ACTIVE_CELLS;
    pwdata = 32'd0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    n_writes = 0;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_active_cells(11'(CELL_DEPTH));
    write_active_cells(11'd1024);

    // every command char, two dropped chars, a counted loop, halt
    send_request(CMD_CLEAR, 8'h00);
    send_request(CMD_STEP, 8'hFF);
    send_request(CMD_LOAD, 8'h00);
    load_text(",+.>-.<[-]#");
    send_request(CMD_LOAD, 8'hFF);
    send_request(CMD_START, 8'h00);
    repeat (16) send_request(CMD_STEP, 8'h02);

    // pointer left beyond a lowered cell count
    send_request(CMD_CLEAR, 8'h00);
    load_text(">>>>>>>>>>><+.");
    send_request(CMD_START, 8'h00);
    repeat (5) send_request(CMD_STEP, 8'h00);
    wait_idle();
    write_active_cells(11'd3);
    send_request(CMD_STEP, 8'h00);
    wait_idle();
    write_active_cells(11'd1024);
    repeat (5) send_request(CMD_STEP, 8'h00);
    wait_idle();
    write_active_cells(11'd3);
    repeat (4) send_request(CMD_STEP, 8'h00);

    // unmatched close, sticky until clear
    send_request(CMD_CLEAR, 8'h00);
    load_text("+]+");
    send_request(CMD_STEP, 8'h00);
    send_request(CMD_START, 8'h00);
    // open loop at step and at start
    send_request(CMD_CLEAR, 8'h00);
    load_text("+[");
    send_request(CMD_STEP, 8'h00);
    send_request(CMD_START, 8'h00);
    send_request(CMD_STEP, 8'h00);
    send_request(CMD_LOAD, CH_INC);
    // nesting too deep
    send_request(CMD_CLEAR, 8'h00);
    repeat (NEST_DEPTH) send_request(CMD_LOAD, CH_OPEN);
    send_request(CMD_STEP, 8'h00);
    send_request(CMD_LOAD, CH_OPEN);
    send_request(CMD_STEP, 8'h00);

    // long program run to the end, no idling on either side
    wait_idle();
    write_active_cells(11'd1024);
    idle_on = 1'b0;
    send_request(CMD_CLEAR, 8'h00);
    repeat (LONG_PROG) send_request(CMD_LOAD, plain_command());
    send_request(CMD_START, 8'h00);
    repeat (LONG_PROG + 1) send_request(CMD_STEP, 8'($urandom_range(255)));
    send_request(CMD_LOAD, CH_INC);
    send_request(CMD_STEP, 8'h00);
    send_request(CMD_CLEAR, 8'h00);
    wait_idle();
    idle_on = 1'b1;

    // random programs
    target = sb.n_requests + RANDOM_REQUESTS;
    episode = 0;
    while (sb.n_requests < target) begin
      if ($urandom_range(99) < 25) begin
        wait_idle();
        write_active_cells(pick_cell_count());
      end
      send_request(CMD_CLEAR, 8'h00);
      len = $urandom_range(40, 4);
      load_program(len);
      r = $urandom_range(99);
      if (r < 4) begin
        send_request(CMD_LOAD, CH_CLOSE);
      end else if (r < 8) begin
        send_request(CMD_LOAD, CH_OPEN);
      end else if (r < 12) begin
        repeat (5) send_request(cmd_t'($urandom_range(3)), 8'($urandom_range(255)));
      end
      if ($urandom_range(99) < 90) send_request(CMD_START, 8'h00);
      steps = $urandom_range(3 * len + 8);
      if (episode % 8 == 3 && steps >= 10) hold_req = 1'b1;
      for (int unsigned i = 0; i < steps; i++) begin
        r = $urandom_range(99);
        if (r < 2) begin
          send_request(CMD_LOAD, 8'($urandom_range(255)));
        end else if (r < 3) begin
          wait_idle();
          write_active_cells(11'($urandom_range(8, 1)));
        end else begin
          send_request(CMD_STEP, 8'($urandom_range(255)));
        end
      end
      episode++;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d requests, %0d results, %0d register writes, %0d output hold-offs",
             sb.n_requests, sb.n_results, n_writes, n_holds);
    $display("results: executed %0d, halted %0d, unmatched %0d, unclosed %0d, capacity %0d",
             sb.status_hits[ST_EXECUTED], sb.status_hits[ST_HALTED],
             sb.status_hits[ST_UNMATCHED], sb.status_hits[ST_UNCLOSED],
             sb.status_hits[ST_CAPACITY]);
    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
